// ----- design/xy_lattice_spin_update_top_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef XY_LATTICE_SPIN_UPDATE_TOP_MACROS_SVH
`define XY_LATTICE_SPIN_UPDATE_TOP_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define XYL_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset
`define XYL_ASSERT(lbl, prop, msg) `XYL_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- design/xyl_pkg.sv -----
`default_nettype none
package xyl_pkg;

  // Register indexes
  localparam logic REG_BETA = 1'b0;
  localparam logic REG_RULE = 1'b1;

  // Item kind and acceptance rule codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic RULE_METRO = 1'b0;

  // Innermost Horner coefficients
  localparam logic [28:0] COS_C10 = 29'd6765;
  localparam logic [29:0] EXP_A7  = 30'd16378;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic       clr_we;
    logic       take;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       cos_init;
    logic       cos_step;
    logic [2:0] cos_k;
    logic       cos_fin;
    logic [2:0] cos_term;
    logic       exp_x;
    logic       exp_y;
    logic       exp_step;
    logic [2:0] exp_k;
    logic       exp_fin;
    logic       cmp_mul;
    logic       commit;
  } cmd_t;

  // Status back to the sequencer
  typedef struct packed {
    logic clr_last;
    logic mode;
    logic out_free;
  } sts_t;

  // cos polynomial coefficients, Q.28, outermost last
  function automatic logic [28:0] cos_coef(input logic [2:0] k);
    logic [28:0] c;
    case (k)
      3'd0:    c = 29'd246762;
      3'd1:    c = 29'd5600498;
      3'd2:    c = 29'd68093890;
      3'd3:    c = 29'd331168970;
      default: c = '0;
    endcase
    return c;
  endfunction

  // 2^-g polynomial coefficients, Q.30, outermost last
  function automatic logic [29:0] exp_coef(input logic [2:0] k);
    logic [29:0] c;
    case (k)
      3'd0:    c = 30'd165394;
      3'd1:    c = 30'd1431680;
      3'd2:    c = 30'd10327388;
      3'd3:    c = 30'd59597094;
      3'd4:    c = 30'd257941247;
      3'd5:    c = 30'd744261118;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/xyl_ram.sv -----
`default_nettype none
module xyl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/xyl_ctrl.sv -----
`default_nettype none
module xyl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire xyl_pkg::sts_t sts_i,
  output xyl_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_COS   = 7'b0001000,
    ST_EXP   = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] ph_q, ph_d;
  logic [2:0] term_q, term_d;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    term_d     = term_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          ph_d       = '0;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // issue site and neighbor reads, capture each in the following cycle
        cmd_o.rd_en   = (ph_q <= 4'd4);
        cmd_o.rd_sel  = ph_q[2:0];
        cmd_o.cap_en  = (ph_q != 4'd0);
        cmd_o.cap_sel = 3'(ph_q - 4'd1);
        if (ph_q == 4'd5) begin
          ph_d    = '0;
          term_d  = '0;
          state_d = ST_COS;
        end else begin
          ph_d = ph_q + 4'd1;
        end
      end
      ST_COS: begin
        cmd_o.cos_term = term_q;
        cmd_o.cos_k    = 3'(ph_q - 4'd1);
        if (ph_q == 4'd0) begin
          cmd_o.cos_init = 1'b1;
          ph_d = ph_q + 4'd1;
        end else if (ph_q <= 4'd5) begin
          cmd_o.cos_step = 1'b1;
          ph_d = ph_q + 4'd1;
        end else begin
          cmd_o.cos_fin = 1'b1;
          ph_d   = '0;
          term_d = term_q + 3'd1;
          if (term_q == 3'd7) begin
            state_d = (sts_i.mode == xyl_pkg::MODE_LOAD) ? ST_WRITE : ST_EXP;
          end
        end
      end
      ST_EXP: begin
        cmd_o.exp_k = 3'(ph_q - 4'd2);
        if (ph_q == 4'd0) begin
          cmd_o.exp_x = 1'b1;
          ph_d = ph_q + 4'd1;
        end else if (ph_q == 4'd1) begin
          cmd_o.exp_y = 1'b1;
          ph_d = ph_q + 4'd1;
        end else if (ph_q <= 4'd7) begin
          cmd_o.exp_step = 1'b1;
          ph_d = ph_q + 4'd1;
        end else begin
          cmd_o.exp_fin = 1'b1;
          ph_d    = '0;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_mul = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ph_q    <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      term_q  <= term_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/xyl_dpath.sv -----
`default_nettype none
module xyl_dpath #(
  parameter int SIDE       = 64,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire xyl_pkg::cmd_t cmd_i,
  output xyl_pkg::sts_t      sts_o,
  input  wire logic [47:0]   s_tdata_i,
  input  wire logic          s_tuser_i,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic      [55:0]   m_tdata_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i
);

  localparam int IW    = $clog2(SIDE);
  localparam int DEPTH = SIDE * SIDE;
  localparam int MAW   = $clog2(DEPTH);
  localparam logic [15:0] ANGLE_MASK = 16'(~((32'd1 << (16 - ANGLE_BITS)) - 32'd1));
  localparam longint ENERGY_RST = -(64'(2) * SIDE * SIDE * 16384);

  function automatic logic [MAW-1:0] site_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [2*IW:0] t;
    t = (2*IW+1)'(r) * (2*IW+1)'(SIDE) + (2*IW+1)'(c);
    return t[MAW-1:0];
  endfunction

  // Row and column reduction modulo SIDE
  logic [IW-1:0] idx_mod [64];
  for (genvar gi = 0; gi < 64; gi++) begin : g_mod
    assign idx_mod[gi] = IW'(gi % SIDE);
  end

  // Item fields
  logic          mode_q;
  logic [IW-1:0] row_q, col_q;
  logic [15:0]   na_q, draw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= s_tuser_i;
      row_q  <= idx_mod[s_tdata_i[5:0]];
      col_q  <= idx_mod[s_tdata_i[11:6]];
      na_q   <= s_tdata_i[27:12] & ANGLE_MASK;
      draw_q <= s_tdata_i[43:28];
    end
  end

  // Configuration registers
  logic [15:0] beta_q;
  logic        rule_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= 16'd4096;
      rule_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == xyl_pkg::REG_BETA) begin
        beta_q <= cfg_data_i;
      end else begin
        rule_q <= cfg_data_i[0];
      end
    end
  end

  // Periodic neighbor indexes
  logic [IW-1:0] rp, rm, cp, cm;
  assign rp = (row_q == IW'(SIDE - 1)) ? '0 : row_q + IW'(1);
  assign rm = (row_q == '0) ? IW'(SIDE - 1) : row_q - IW'(1);
  assign cp = (col_q == IW'(SIDE - 1)) ? '0 : col_q + IW'(1);
  assign cm = (col_q == '0) ? IW'(SIDE - 1) : col_q - IW'(1);

  logic [MAW-1:0] rd_addr, site;
  assign site = site_addr(row_q, col_q);

  always_comb begin
    case (cmd_i.rd_sel)
      3'd1:    rd_addr = site_addr(rp, col_q);
      3'd2:    rd_addr = site_addr(rm, col_q);
      3'd3:    rd_addr = site_addr(row_q, cp);
      3'd4:    rd_addr = site_addr(row_q, cm);
      default: rd_addr = site;
    endcase
  end

  // Clear sweep after reset
  logic [MAW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_q + MAW'(1);
    end
  end

  // Lattice memory
  logic           acc;
  logic           ram_we;
  logic [MAW-1:0] ram_waddr;
  logic [15:0]    ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.clr_we | (cmd_i.commit & acc);
  assign ram_waddr = cmd_i.clr_we ? clr_q : site;
  assign ram_wdata = cmd_i.clr_we ? 16'd0 : na_q;

  xyl_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Site and neighbor angles
  logic [15:0] old_q;
  logic [15:0] nb_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_sel)
        3'd1:    nb_q[0] <= ram_rdata;
        3'd2:    nb_q[1] <= ram_rdata;
        3'd3:    nb_q[2] <= ram_rdata;
        3'd4:    nb_q[3] <= ram_rdata;
        default: old_q   <= ram_rdata;
      endcase
    end
  end

  // Cosine unit: quadrant fold, then Horner in z, one product a cycle
  logic [15:0]        diff;
  logic [14:0]        u;
  logic [29:0]        uu;
  logic [14:0]        z_q;
  logic               neg_q;
  logic [28:0]        cp_q;
  logic signed [30:0] v_q;
  logic [43:0]        cprod;
  logic [29:0]        csh;
  logic [29:0]        vc;
  logic [30:0]        rsum;
  logic [14:0]        cmag;
  logic signed [18:0] de_q;
  logic               flip;

  assign diff  = (cmd_i.cos_term[0] ? na_q : old_q) - nb_q[cmd_i.cos_term[2:1]];
  assign u     = diff[14] ? 15'(15'd16384 - {1'b0, diff[13:0]}) : {1'b0, diff[13:0]};
  assign uu    = 30'(u) * 30'(u);
  assign cprod = 44'(cp_q) * 44'(z_q);
  assign csh   = cprod[43:14];
  assign vc    = v_q[30] ? '0 : v_q[29:0];
  assign rsum  = {1'b0, vc} + 31'd8192;
  assign cmag  = (rsum[30:14] > 17'd16384) ? 15'd16384 : rsum[28:14];
  assign flip  = neg_q ^ cmd_i.cos_term[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      de_q <= '0;
    end
    if (cmd_i.cos_init) begin
      z_q   <= uu[28:14];
      neg_q <= diff[15] ^ diff[14];
      cp_q  <= xyl_pkg::COS_C10;
    end
    if (cmd_i.cos_step) begin
      if (cmd_i.cos_k < 3'd4) begin
        cp_q <= xyl_pkg::cos_coef(cmd_i.cos_k) - csh[28:0];
      end else begin
        v_q <= 31'(32'sd268435456 - $signed({2'b0, csh}));
      end
    end
    if (cmd_i.cos_fin) begin
      de_q <= flip ? de_q - $signed({4'b0, cmag}) : de_q + $signed({4'b0, cmag});
    end
  end

  // exp(-beta*|dE|): scale, split into 2^-k * 2^-g, Horner in g
  logic [17:0] mag;
  logic [33:0] x_q;
  logic [50:0] yprod;
  logic [8:0]  yk;
  logic        kbig_q;
  logic [4:0]  kamt_q;
  logic [25:0] g_q;
  logic [29:0] ep_q;
  logic [55:0] eprod;
  logic [29:0] esh;
  logic [30:0] et;
  logic [30:0] e_q;

  assign mag   = de_q[18] ? 18'(-de_q) : de_q[17:0];
  assign yprod = 51'(x_q) * 51'd94548;
  assign yk    = yprod[50:42];
  assign eprod = 56'(ep_q) * 56'(g_q);
  assign esh   = eprod[55:26];
  assign et    = 31'h4000_0000 - {1'b0, esh};

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_x) begin
      x_q <= 34'(beta_q) * 34'(mag);
    end
    if (cmd_i.exp_y) begin
      kbig_q <= (yk > 9'd30);
      kamt_q <= yk[4:0];
      g_q    <= yprod[41:16];
      ep_q   <= xyl_pkg::EXP_A7;
    end
    if (cmd_i.exp_step) begin
      ep_q <= xyl_pkg::exp_coef(cmd_i.exp_k) - esh;
    end
    if (cmd_i.exp_fin) begin
      e_q <= kbig_q ? '0 : et >> kamt_q;
    end
  end

  // Acceptance: Metropolis compares the draw against E; heat bath compares (draw+1)*(1+E) against the numerator
  logic [29:0] draw14;
  logic [62:0] prod_q;
  logic [62:0] num;
  logic        de_pos, metro, heat;

  assign draw14 = {draw_q, 14'b0};
  assign de_pos = !de_q[18] && (de_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_mul) begin
      prod_q <= 63'(31'(draw14) + 31'd1) * 63'(32'h4000_0000 + 32'(e_q));
    end
  end

  assign num   = de_pos ? 63'({e_q, 30'b0}) : (63'd1 << 60);
  assign metro = !de_pos || (31'(draw14) < e_q);
  assign heat  = (prod_q <= num);

  always_comb begin
    if (mode_q == xyl_pkg::MODE_LOAD) begin
      acc = 1'b1;
    end else if (rule_q == xyl_pkg::RULE_METRO) begin
      acc = metro;
    end else begin
      acc = heat;
    end
  end

  // Energy total and result register
  logic [28:0] energy_q, energy_new;
  logic        out_valid_q;
  logic        out_acc_q;
  logic [18:0] out_de_q;
  logic [28:0] out_en_q;

  assign energy_new = energy_q + {{10{de_q[18]}}, de_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= 29'(ENERGY_RST);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (acc) energy_q <= energy_new;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_acc_q <= acc;
      out_de_q  <= de_q;
      out_en_q  <= acc ? energy_new : energy_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'b0, out_en_q, out_de_q, out_acc_q};

  assign sts_o.clr_last = (clr_q == MAW'(DEPTH - 1));
  assign sts_o.mode     = mode_q;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

endmodule
`default_nettype wire

// ----- design/xy_lattice_spin_update_top.sv -----
// XY lattice spin update.
// Input channel (s_*): one beat per item; tuser selects load (0) or propose (1),
// tdata carries site, new angle and uniform draw. Output channel (m_*): one
// beat per item with the accept flag, the energy change and the new total.
// Config port: cfg_we_i writes inverse temperature (index 0) or the
// acceptance rule (index 1); write only while the block is idle.
// Datapath: the five lattice reads (site and four neighbors) share one memory
// read port, then eight cosines run in turn through one iterative Horner unit,
// then a proposal runs the exp unit and a registered product for the test.
// One item is in flight at a time.
// Reset: the lattice memory is swept to zero with s_tready_o low; energy
// restarts at -2*SIDE^2.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile and holds before its write-back until that beat is taken.
`default_nettype none
module xy_lattice_spin_update_top #(
  parameter int SIDE       = 64,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // row_index[5:0], col_index[11:6], new_angle[27:12], random_draw[43:28]
  input  wire logic [47:0] s_tdata_i,
  // mode[0]
  input  wire logic        s_tuser_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // accepted[0], energy_change[19:1], energy_total[48:20]
  output logic      [55:0] m_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  xyl_pkg::cmd_t cmd;
  xyl_pkg::sts_t sts;

  xyl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xyl_dpath #(
    .SIDE       (SIDE),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
`default_nettype wire

// ----- design/xyl_chk.sv -----
`default_nettype none
`include "xy_lattice_spin_update_top_macros.svh"
module xyl_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [55:0] m_tdata_o
);

  // output beat holds while stalled
  `XYL_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o, "result dropped")
  `XYL_ASSERT(a_out_stable, m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o), "result changed")

  // one item at a time: ready drops right after an accepted beat
  `XYL_ASSERT(a_one_item, s_tvalid_i && s_tready_o |=> !s_tready_o, "second item taken")

  // a result never appears the cycle after an accept
  `XYL_ASSERT(a_no_early, s_tvalid_i && s_tready_o |=> !$rose(m_tvalid_o), "early result")

endmodule

bind xy_lattice_spin_update_top xyl_chk u_chk (.*);
`default_nettype wire
